[design/mbf_pkg.sv]
`timescale 1ns / 1ps
// mbf_pkg: shared types, character codes and limits for the matching brace finder
// used by mbf_scan and matching_brace_finder_unit; depends on nothing else
package mbf_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned DEPTH_W = 16;

    // counter limits: min(max text length, 65535) and min(max nesting depth, 65535)
    localparam logic [POS_W-1:0]   POS_LIMIT   = 16'hFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 16'hFFFF;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic STATUS_FOUND    = 1'b0;
    localparam logic STATUS_NO_MATCH = 1'b1;

    typedef enum logic [2:0] {
        PH_AWAIT = 3'b001,
        PH_SCAN  = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        Q_NONE     = 2'd0,
        Q_DOUBLE   = 2'd1,
        Q_SINGLE   = 2'd2,
        Q_BACKTICK = 2'd3
    } quote_t;

    typedef enum logic [1:0] {
        C_NONE  = 2'd0,
        C_LINE  = 2'd1,
        C_BLOCK = 2'd2
    } comment_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]   pos;
        quote_t             quote;
        logic               escape;
        logic               slash;
        comment_t           comment;
        logic               star;
        phase_t             phase;
    } scan_state_t;

    typedef struct packed {
        logic             valid;
        logic             status;
        logic [POS_W-1:0] offset;
    } scan_result_t;

    localparam scan_state_t ST_RESET = '{
        depth:   '0,
        pos:     '0,
        quote:   Q_NONE,
        escape:  1'b0,
        slash:   1'b0,
        comment: C_NONE,
        star:    1'b0,
        phase:   PH_AWAIT
    };

    // closing character for an open string
    function automatic logic [7:0] quote_char(input quote_t q);
        logic [7:0] c;
        case (q)
            Q_DOUBLE:   c = CH_DQUOTE;
            Q_SINGLE:   c = CH_SQUOTE;
            Q_BACKTICK: c = CH_BACKTICK;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[design/mbf_scan.sv]
`timescale 1ns / 1ps
// mbf_scan: next-state and result logic for one text byte
// depends on mbf_pkg
module mbf_scan (
    input  mbf_pkg::scan_state_t  state,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output mbf_pkg::scan_state_t  state_next,
    output mbf_pkg::scan_result_t result
);
    import mbf_pkg::*;

    always_comb
    begin
        scan_state_t        nxt;
        scan_result_t       res;
        logic               found;
        logic               fail;
        logic               handled;
        logic [DEPTH_W-1:0] depth_dec;

        nxt       = state;
        res       = '{valid: 1'b0, status: STATUS_FOUND, offset: '0};
        found     = 1'b0;
        fail      = 1'b0;
        handled   = 1'b0;
        depth_dec = state.depth;

        case (state.phase)
            PH_AWAIT:
            begin
                nxt = ST_RESET;
                if (data_byte == CH_LBRACE)
                begin
                    nxt.depth = DEPTH_W'(1);
                    nxt.phase = PH_SCAN;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_SCAN:
            begin
                if (state.pos >= POS_LIMIT)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    nxt.pos = state.pos + POS_W'(1);
                    if (state.escape)
                    begin
                        nxt.escape = 1'b0;
                    end
                    else if (state.quote != Q_NONE)
                    begin
                        if (data_byte == CH_BACKSLASH)
                            nxt.escape = 1'b1;
                        else if (data_byte == quote_char(state.quote))
                            nxt.quote = Q_NONE;
                    end
                    else if (state.comment == C_LINE)
                    begin
                        if (data_byte == CH_NEWLINE)
                            nxt.comment = C_NONE;
                    end
                    else if (state.comment == C_BLOCK)
                    begin
                        if (state.star && data_byte == CH_SLASH)
                        begin
                            nxt.comment = C_NONE;
                            nxt.star    = 1'b0;
                        end
                        else
                        begin
                            nxt.star = (data_byte == CH_STAR);
                        end
                    end
                    else
                    begin
                        // a pending slash either opens a comment or is dropped
                        if (state.slash)
                        begin
                            nxt.slash = 1'b0;
                            if (data_byte == CH_SLASH)
                            begin
                                nxt.comment = C_LINE;
                                handled     = 1'b1;
                            end
                            else if (data_byte == CH_STAR)
                            begin
                                nxt.comment = C_BLOCK;
                                nxt.star    = 1'b0;
                                handled     = 1'b1;
                            end
                        end
                        if (!handled)
                        begin
                            if (data_byte == CH_DQUOTE)
                                nxt.quote = Q_DOUBLE;
                            else if (data_byte == CH_SQUOTE)
                                nxt.quote = Q_SINGLE;
                            else if (data_byte == CH_BACKTICK)
                                nxt.quote = Q_BACKTICK;
                            else if (data_byte == CH_SLASH)
                                nxt.slash = 1'b1;
                            else if (data_byte == CH_LBRACE)
                            begin
                                if (state.depth >= DEPTH_LIMIT)
                                    fail = 1'b1;
                                else
                                    nxt.depth = state.depth + DEPTH_W'(1);
                            end
                            else if (data_byte == CH_RBRACE)
                            begin
                                if (state.depth != '0)
                                    depth_dec = state.depth - DEPTH_W'(1);
                                nxt.depth = depth_dec;
                                if (depth_dec == '0)
                                    found = 1'b1;
                            end
                        end
                    end
                end
            end
            PH_DONE:
            begin
                nxt.phase = PH_DONE;
            end
            default:
            begin
                nxt = ST_RESET;
            end
        endcase

        if (found)
        begin
            res.valid  = 1'b1;
            res.status = STATUS_FOUND;
            res.offset = nxt.pos;
            nxt.phase  = PH_DONE;
        end
        else if (fail)
        begin
            res.valid  = 1'b1;
            res.status = STATUS_NO_MATCH;
            res.offset = '0;
            nxt.phase  = PH_DONE;
        end

        // end of text: an open search gives no match, then everything clears
        if (last_byte)
        begin
            if (nxt.phase == PH_SCAN)
            begin
                res.valid  = 1'b1;
                res.status = STATUS_NO_MATCH;
                res.offset = '0;
            end
            nxt = ST_RESET;
        end

        state_next = nxt;
        result     = res;
    end

endmodule

[design/matching_brace_finder_unit.sv]
`timescale 1ns / 1ps
// matching_brace_finder_unit: top level of the matching brace finder
// depends on mbf_pkg and mbf_scan
//
// Takes a source text one byte per word, starting at an opening brace, and finds
// the brace that closes it, skipping braces inside double, single and backtick
// strings (with backslash escapes), line comments and block comments. Exactly one
// result word is produced per text: the offset of the closing brace from the
// opener with status 0, or status 1 and offset 0 when there is no match (first
// byte not a brace, text ends unbalanced or inside a comment or string, offset
// or nesting depth past 65535). After a result, bytes are dropped up to tlast,
// and the byte after tlast starts a new text. The unit takes one byte per clock when
// not stalled; the scan state register is updated from each byte in the same cycle,
// and a result is registered on the output register in the cycle after the byte
// that causes it. The input side only stalls while a result is held and not taken.
module matching_brace_finder_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] brace_offset
    output logic        m_axis_tuser    // [0] status
);
    import mbf_pkg::*;

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t scan_res;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_status_reg;
    logic [POS_W-1:0] out_offset_reg;
    logic             in_accept;

    // one byte of work: flags, depth and position update
    mbf_scan u_scan (
        .state      (state_reg),
        .data_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .state_next (state_next),
        .result     (scan_res)
    );

    // a held result only blocks input when it is not being taken this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept && scan_res.valid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && scan_res.valid)
        begin
            out_status_reg <= scan_res.status;
            out_offset_reg <= scan_res.offset;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_offset_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for matching_brace_finder_unit, a directed table then random texts
// depends on mbf_pkg and the design; every result checked by a local predictor or a typed row
module tb_top;
    import mbf_pkg::*;

    localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no handshake on either side
    localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int unsigned RANDOM_ITEMS = 1720;
    localparam int unsigned TAIL_ITEMS   = 250;   // closing stretch with no idling
    localparam int unsigned DIR_ROWS_N   = 28;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam logic [7:0] CH_MIN    = 8'h00;
    localparam logic [7:0] CH_MAX    = 8'hFF;

    typedef enum logic [1:0] {
        SV_CONT,
        SV_HIT,
        SV_ABORT
    } scan_verdict_t;

    typedef struct packed {
        logic        status;
        logic [15:0] offset;
    } brace_result_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          last;
        logic          typed;
        brace_result_t res;
    } dir_row_t;

    // directed texts: not-a-brace opener, shortest match, a single-quote string with an
    // escape, a backtick string, line comment, block comment whose opener star cannot
    // close it, lone slash, and a text that ends inside a string
    localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
        '{CH_MIN,       1'b0, TYPED,     '{STATUS_NO_MATCH, 16'd0}},
        '{CH_MAX,       1'b1, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_LBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_RBRACE,    1'b1, TYPED,     '{STATUS_FOUND, 16'd1}},
        '{CH_LBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SQUOTE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_RBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_BACKSLASH, 1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SQUOTE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SQUOTE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_BACKTICK,  1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_LBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_BACKTICK,  1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SLASH,     1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SLASH,     1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_RBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_NEWLINE,   1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SLASH,     1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_STAR,      1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SLASH,     1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_RBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_STAR,      1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SLASH,     1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_SLASH,     1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_RBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_MAX,       1'b1, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_LBRACE,    1'b0, PREDICTED, '{STATUS_FOUND, 16'd0}},
        '{CH_DQUOTE,    1'b1, TYPED,     '{STATUS_NO_MATCH, 16'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    // expectation carried alongside the word on the input side
    logic          cur_typed;
    brace_result_t cur_result;

    brace_result_t pending_results [$];
    int unsigned   mismatches;
    int unsigned   words_sent;
    int unsigned   quiet_cycles;
    bit            src_idle_on;
    bit            snk_idle_on;
    bit            hold_req;

    // predictor copy of the scanner state
    logic [15:0] p_depth;
    logic [15:0] p_pos;
    quote_t      p_quote;
    logic        p_escape;
    logic        p_slash;
    comment_t    p_comment;
    logic        p_star;
    phase_t      p_phase;

    matching_brace_finder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_scan();
        p_depth   = '0;
        p_pos     = '0;
        p_quote   = Q_NONE;
        p_escape  = 1'b0;
        p_slash   = 1'b0;
        p_comment = C_NONE;
        p_star    = 1'b0;
        p_phase   = PH_AWAIT;
    endfunction

    // one byte of an open text; strings win over comments, comments over braces
    function automatic scan_verdict_t scan_char(input logic [7:0] b);
        logic closes;
        if (p_pos >= POS_LIMIT)
            return SV_ABORT;
        p_pos = p_pos + 16'd1;
        if (p_escape)
        begin
            p_escape = 1'b0;
            return SV_CONT;
        end
        if (p_quote != Q_NONE)
        begin
            closes = (p_quote == Q_DOUBLE && b == CH_DQUOTE)
                  || (p_quote == Q_SINGLE && b == CH_SQUOTE)
                  || (p_quote == Q_BACKTICK && b == CH_BACKTICK);
            if (b == CH_BACKSLASH)
                p_escape = 1'b1;
            else if (closes)
                p_quote = Q_NONE;
            return SV_CONT;
        end
        if (p_comment == C_LINE)
        begin
            if (b == CH_NEWLINE)
                p_comment = C_NONE;
            return SV_CONT;
        end
        if (p_comment == C_BLOCK)
        begin
            if (p_star && b == CH_SLASH)
            begin
                p_comment = C_NONE;
                p_star    = 1'b0;
            end
            else
            begin
                p_star = (b == CH_STAR);
            end
            return SV_CONT;
        end
        if (p_slash)
        begin
            p_slash = 1'b0;
            if (b == CH_SLASH)
            begin
                p_comment = C_LINE;
                return SV_CONT;
            end
            if (b == CH_STAR)
            begin
                p_comment = C_BLOCK;
                p_star    = 1'b0;
                return SV_CONT;
            end
        end
        case (b)
            CH_DQUOTE:   p_quote = Q_DOUBLE;
            CH_SQUOTE:   p_quote = Q_SINGLE;
            CH_BACKTICK: p_quote = Q_BACKTICK;
            CH_SLASH:    p_slash = 1'b1;
            CH_LBRACE:
            begin
                if (p_depth >= DEPTH_LIMIT)
                    return SV_ABORT;
                p_depth = p_depth + 16'd1;
            end
            CH_RBRACE:
            begin
                if (p_depth != 0)
                    p_depth = p_depth - 16'd1;
                if (p_depth == 0)
                    return SV_HIT;
            end
            default: ;
        endcase
        return SV_CONT;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic l,
                                         output logic got, output brace_result_t res);
        scan_verdict_t v;
        got = 1'b0;
        res = '{STATUS_NO_MATCH, 16'd0};
        case (p_phase)
            PH_AWAIT:
            begin
                clear_scan();
                if (b == CH_LBRACE)
                begin
                    p_depth = 16'd1;
                    p_phase = PH_SCAN;
                end
                else
                begin
                    got     = 1'b1;
                    p_phase = PH_DONE;
                end
            end
            PH_SCAN:
            begin
                v = scan_char(b);
                if (v == SV_HIT)
                begin
                    got     = 1'b1;
                    res     = '{STATUS_FOUND, p_pos};
                    p_phase = PH_DONE;
                end
                else if (v == SV_ABORT)
                begin
                    got     = 1'b1;
                    p_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        if (l)
        begin
            // still open at the end of the text: unbalanced
            if (p_phase == PH_SCAN)
                got = 1'b1;
            clear_scan();
        end
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // accepted words on both sides: predict on input, compare on output
    always @(posedge clk)
    begin : monitor
        logic          got;
        brace_result_t res;
        brace_result_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_byte(s_axis_tdata, s_axis_tlast, got, res);
            if (cur_typed)
                pending_results = {pending_results, cur_result};
            else if (got)
                pending_results = {pending_results, res};
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result word status %0b offset %0d",
                                        m_axis_tuser, m_axis_tdata));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    flag_mismatch($sformatf("status %0b, wanted %0b",
                                            m_axis_tuser, want.status));
                if (m_axis_tdata !== want.offset)
                    flag_mismatch($sformatf("brace offset %0d, wanted %0d",
                                            m_axis_tdata, want.offset));
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left     = 0;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (snk_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run if neither side moves for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // offers one byte word, with an optional idle burst first, and waits for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input brace_result_t res);
        int unsigned gap;
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        cur_typed     <= typed;
        cur_result    <= res;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // weighted towards the characters the scanner reacts to
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 18) return CH_LBRACE;
        if (r < 36) return CH_RBRACE;
        if (r < 42) return CH_DQUOTE;
        if (r < 47) return CH_SQUOTE;
        if (r < 52) return CH_BACKTICK;
        if (r < 60) return CH_SLASH;
        if (r < 66) return CH_STAR;
        if (r < 70) return CH_NEWLINE;
        if (r < 74) return CH_BACKSLASH;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_text();
        int unsigned body;
        logic [7:0]  first;
        brace_result_t none;
        none  = '{STATUS_FOUND, 16'd0};
        // mostly a proper opener, sometimes noise
        first = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_LBRACE;
        body  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 20);
        send_byte(first, body == 0, PREDICTED, none);
        for (int unsigned k = 1; k <= body; k++)
            send_byte(pick_char(), k == body, PREDICTED, none);
    endtask

    initial
    begin : stimulus
        brace_result_t none;
        none          = '{STATUS_FOUND, 16'd0};
        mismatches    = 0;
        words_sent    = 0;
        src_idle_on   = 1'b1;
        snk_idle_on   = 1'b1;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cur_typed     = PREDICTED;
        cur_result    = none;
        clear_scan();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int unsigned i = 0; i < DIR_ROWS_N; i++)
            send_byte(DIR_ROWS[i].ch, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].res);

        // random texts; the receiver holds off once so the output fills and the input stalls
        hold_req = 1'b1;
        while (words_sent < DIR_ROWS_N + RANDOM_ITEMS - TAIL_ITEMS)
        begin
            src_idle_on = ($urandom_range(0, 4) != 0);
            snk_idle_on = ($urandom_range(0, 4) != 0);
            send_random_text();
        end

        // last part: no idling on either side
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        while (words_sent < DIR_ROWS_N + RANDOM_ITEMS)
            send_random_text();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain, then a short settle for anything unexpected
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[matching_brace_finder_unit.f]
design/mbf_pkg.sv
design/mbf_scan.sv
design/matching_brace_finder_unit.sv
test/tb_top.sv
